>>> hw/rtl/wtls_pkg.sv
// ----------------------------------------------------------------------------
// wtls_pkg
// shared widths, codes and fixed-point helpers of the tank level stepper
// ----------------------------------------------------------------------------
package wtls_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int DT_W      = 31;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * DATA_W;

  // square root of level << FRAC_BITS, two radicand bits per step
  localparam int SQRT_STEPS = (DATA_W + FRAC_BITS) / 2;
  localparam int SQ_W       = 2 * SQRT_STEPS;
  // long division of |e| << FRAC_BITS, one quotient bit per step
  localparam int DIV_W      = DATA_W + FRAC_BITS;
  localparam int CNT_W      = $clog2(DIV_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TANK_AREA     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAIN_OFFSET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INFLOW_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTFLOW_COEFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLET_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd6;

  // commands
  localparam logic CMD_INTEGRATE = 1'b0;
  localparam logic CMD_RESTART   = 1'b1;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] MUL_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  // magnitude of a two's complement word
  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
  endfunction

  // clamp a sum carrying one extra sign bit
  function automatic logic [DATA_W-1:0] sat_sum(input logic [DATA_W:0] v);
    logic ovf;
    ovf = v[DATA_W] ^ v[DATA_W-1];
    if (ovf) begin
      return v[DATA_W] ? SAT_MIN : SAT_MAX;
    end
    return v[DATA_W-1:0];
  endfunction

  // apply sign to a wide magnitude and clamp
  function automatic logic [DATA_W-1:0] sat_mag(input logic [PROD_W-1:0] r,
                                                input logic neg);
    logic over_neg;
    logic over_pos;
    over_neg = r > (PROD_W'(1) << (DATA_W - 1));
    over_pos = r > ((PROD_W'(1) << (DATA_W - 1)) - PROD_W'(1));
    if (neg) begin
      return over_neg ? SAT_MIN : (~r[DATA_W-1:0] + DATA_W'(1));
    end
    return over_pos ? SAT_MAX : r[DATA_W-1:0];
  endfunction

endpackage

>>> hw/rtl/wtls_cfg_if.sv
// ----------------------------------------------------------------------------
// wtls_cfg_if
// register write channel of the tank level stepper
// ----------------------------------------------------------------------------
interface wtls_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wtls_pkg::CFG_IDX_W-1:0] index;
  logic [wtls_pkg::DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/wtls_in_if.sv
// ----------------------------------------------------------------------------
// wtls_in_if
// command channel of the tank level stepper
// ----------------------------------------------------------------------------
interface wtls_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [wtls_pkg::DATA_W-1:0] inflow_drive;

  modport source (output valid, output cmd, output inflow_drive, input ready);
  modport sink   (input valid, input cmd, input inflow_drive, output ready);
endinterface

>>> hw/rtl/wtls_out_if.sv
// ----------------------------------------------------------------------------
// wtls_out_if
// result channel of the tank level stepper
// ----------------------------------------------------------------------------
interface wtls_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wtls_pkg::DATA_W-1:0] new_level;
  logic                               param_error;

  modport source (output valid, output new_level, output param_error, input ready);
  modport sink   (input valid, input new_level, input param_error, output ready);
endinterface

>>> hw/rtl/water_tank_level_step.sv
// ----------------------------------------------------------------------------
// water_tank_level_step
// one forward-euler step of a torricelli single-tank model per item
// ----------------------------------------------------------------------------
// usage
//   cfg_i  register writes (area, drain, gain, outlet coeff, outlet count,
//          initial level, time step), always ready, write only while idle
//   in_i   one item: cmd (integrate or restart) and the inflow drive u
//   out_o  one item per input item: new level and the parameter error flag
// sequencing
//   restart, held (bad parameters) and empty-tank items go from idle
//   straight to the output state; integrate items run the bit-serial
//   datapath: SQRT_STEPS square root steps, four multiplies of DATA_W
//   steps, each with a rounding state, then DIV_W divider steps, a
//   rounding state and the level update; one item is worked at a time
//   and in_i is ready only when idle, after the output state is left
// reset
//   registers return to their defaults and the stored level to zero
// stall
//   a finished item sits in the output register; the next item may be
//   accepted meanwhile, but its result waits in the output state until
//   the receiver takes the previous one
// ----------------------------------------------------------------------------
module water_tank_level_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  wtls_cfg_if.sink    cfg_i,
  wtls_in_if.sink     in_i,
  wtls_out_if.source  out_o
);
  import wtls_pkg::*;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQRT = 4'd1;
  localparam logic [3:0] ST_NEXT = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_MFIN = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_DFIN = 4'd6;
  localparam logic [3:0] ST_UPD  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  // operation phases, each launched from ST_NEXT
  localparam logic [2:0] PH_P1 = 3'd0;  // a * s
  localparam logic [2:0] PH_P2 = 3'd1;  // q * (p1 + F)
  localparam logic [2:0] PH_P3 = 3'd2;  // b * u
  localparam logic [2:0] PH_E  = 3'd3;  // dt * (p3 - p2)
  localparam logic [2:0] PH_F  = 3'd4;  // e / A

  // configuration registers
  logic [DATA_W-1:0] area_q, area_d;
  logic [DATA_W-1:0] drain_q, drain_d;
  logic [DATA_W-1:0] gain_q, gain_d;
  logic [DATA_W-1:0] coeff_q, coeff_d;
  logic [DATA_W-1:0] count_q, count_d;
  logic [DATA_W-1:0] init_q, init_d;
  logic [DT_W-1:0]   dt_q, dt_d;

  // control
  logic [3:0]        state_q, state_d;
  logic [2:0]        ph_q, ph_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] level_q, level_d;
  logic              out_valid_q, out_valid_d;

  // datapath
  logic [DATA_W-1:0]       u_q, u_d;
  logic                    err_q, err_d;
  logic [SQ_W-1:0]         rad_q, rad_d;
  logic [SQRT_STEPS-1:0]   root_q, root_d;
  logic [SQRT_STEPS:0]     srem_q, srem_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic [DATA_W-1:0]       mcand_q, mcand_d;
  logic                    neg_q, neg_d;
  logic [DATA_W-1:0]       res_q, res_d;
  logic [DATA_W-1:0]       p2_q, p2_d;
  logic [DATA_W-1:0]       drem_q, drem_d;
  logic [DIV_W-1:0]        dq_q, dq_d;
  logic [DATA_W-1:0]       out_level_q, out_level_d;
  logic                    out_err_q, out_err_d;

  // combinational helpers
  logic [SQRT_STEPS+2:0]   sq_r2;
  logic [SQRT_STEPS+2:0]   sq_trial;
  logic [SQRT_STEPS+2:0]   sq_diff;
  logic                    sq_ge;
  logic [SQRT_STEPS-1:0]   root_nx;
  logic [DATA_W:0]         mul_sum;
  logic [DATA_W:0]         dv_sh;
  logic [DATA_W:0]         dv_den;
  logic                    dv_ge;
  logic                    dv_rnd;
  logic [DATA_W-1:0]       op_x;
  logic [DATA_W-1:0]       op_y;
  logic                    bad_param;
  logic                    in_fire;
  logic                    out_load;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && (state_q == ST_IDLE);

  assign out_o.valid       = out_valid_q;
  assign out_o.new_level   = out_level_q;
  assign out_o.param_error = out_err_q;

  // A <= 0, b <= 0, a <= 0 or q < 0
  assign bad_param = area_q[DATA_W-1]  || (area_q == '0)  ||
                     gain_q[DATA_W-1]  || (gain_q == '0)  ||
                     coeff_q[DATA_W-1] || (coeff_q == '0) ||
                     count_q[DATA_W-1];

  // restoring square root step: bring down two radicand bits
  assign sq_r2    = {srem_q, rad_q[SQ_W-1 -: 2]};
  assign sq_trial = (SQRT_STEPS+3)'({root_q, 2'b01});
  assign sq_ge    = sq_r2 >= sq_trial;
  assign sq_diff  = sq_r2 - sq_trial;
  assign root_nx  = {root_q[SQRT_STEPS-2:0], sq_ge};

  // shift-add multiplier step on magnitudes
  assign mul_sum = {1'b0, prod_q[PROD_W-1:DATA_W]} +
                   (prod_q[0] ? {1'b0, mcand_q} : '0);

  // restoring divider step, divisor is the positive tank area
  assign dv_sh  = {drem_q, dq_q[DIV_W-1]};
  assign dv_den = {1'b0, area_q};
  assign dv_ge  = dv_sh >= dv_den;
  // round half up on the magnitude: 2 * remainder >= divisor
  assign dv_rnd = {drem_q, 1'b0} >= dv_den;

  // operands of the next multiply
  always_comb begin
    op_x = coeff_q;
    op_y = res_q;
    case (ph_q)
      PH_P1: begin
        op_x = coeff_q;
        op_y = res_q;
      end
      PH_P2: begin
        op_x = count_q;
        op_y = sat_sum({res_q[DATA_W-1], res_q} + {drain_q[DATA_W-1], drain_q});
      end
      PH_P3: begin
        op_x = gain_q;
        op_y = u_q;
      end
      PH_E: begin
        op_x = {1'b0, dt_q};
        op_y = sat_sum({res_q[DATA_W-1], res_q} - {p2_q[DATA_W-1], p2_q});
      end
      default: begin
        op_x = coeff_q;
        op_y = res_q;
      end
    endcase
  end

  // output register may load when empty or being drained
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    area_d  = area_q;
    drain_d = drain_q;
    gain_d  = gain_q;
    coeff_d = coeff_q;
    count_d = count_q;
    init_d  = init_q;
    dt_d    = dt_q;

    state_d     = state_q;
    ph_d        = ph_q;
    cnt_d       = cnt_q;
    level_d     = level_q;
    out_valid_d = out_valid_q && !out_o.ready;

    u_d         = u_q;
    err_d       = err_q;
    rad_d       = rad_q;
    root_d      = root_q;
    srem_d      = srem_q;
    prod_d      = prod_q;
    mcand_d     = mcand_q;
    neg_d       = neg_q;
    res_d       = res_q;
    p2_d        = p2_q;
    drem_d      = drem_q;
    dq_d        = dq_q;
    out_level_d = out_level_q;
    out_err_d   = out_err_q;

    // register writes
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_TANK_AREA:     area_d  = cfg_i.data;
        REG_DRAIN_OFFSET:  drain_d = cfg_i.data;
        REG_INFLOW_GAIN:   gain_d  = cfg_i.data;
        REG_OUTFLOW_COEFF: coeff_d = cfg_i.data;
        REG_OUTLET_COUNT:  count_d = cfg_i.data;
        REG_INITIAL_LEVEL: init_d  = cfg_i.data;
        REG_TIME_STEP:     dt_d    = cfg_i.data[DT_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          u_d   = in_i.inflow_drive;
          err_d = 1'b0;
          if (in_i.cmd == CMD_RESTART) begin
            level_d = init_q;
            state_d = ST_OUT;
          end else if (bad_param) begin
            // level held, flag raised
            err_d   = 1'b1;
            state_d = ST_OUT;
          end else if (level_q[DATA_W-1] || (level_q == '0)) begin
            // empty tank
            level_d = '0;
            state_d = ST_OUT;
          end else begin
            rad_d   = SQ_W'({level_q[DATA_W-2:0], {FRAC_BITS{1'b0}}});
            root_d  = '0;
            srem_d  = '0;
            cnt_d   = CNT_W'(SQRT_STEPS - 1);
            state_d = ST_SQRT;
          end
        end
      end

      ST_SQRT: begin
        rad_d  = {rad_q[SQ_W-3:0], 2'b00};
        root_d = root_nx;
        srem_d = sq_ge ? sq_diff[SQRT_STEPS:0] : sq_r2[SQRT_STEPS:0];
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          res_d   = DATA_W'(root_nx);
          ph_d    = PH_P1;
          state_d = ST_NEXT;
        end
      end

      ST_NEXT: begin
        if (ph_q == PH_F) begin
          // divide |e| << FRAC_BITS by A
          neg_d   = res_q[DATA_W-1];
          dq_d    = {mag(res_q), {FRAC_BITS{1'b0}}};
          drem_d  = '0;
          cnt_d   = CNT_W'(DIV_W - 1);
          state_d = ST_DIV;
        end else begin
          if (ph_q == PH_P3) begin
            p2_d = res_q;
          end
          neg_d   = op_x[DATA_W-1] ^ op_y[DATA_W-1];
          mcand_d = mag(op_x);
          prod_d  = {{DATA_W{1'b0}}, mag(op_y)};
          cnt_d   = CNT_W'(DATA_W - 1);
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_d = {mul_sum, prod_q[DATA_W-1:1]};
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_MFIN;
        end
      end

      ST_MFIN: begin
        // round half away from zero, then saturate
        res_d   = sat_mag((prod_q + MUL_HALF) >> FRAC_BITS, neg_q);
        ph_d    = ph_q + 3'd1;
        state_d = ST_NEXT;
      end

      ST_DIV: begin
        drem_d = dv_ge ? DATA_W'(dv_sh - dv_den) : dv_sh[DATA_W-1:0];
        dq_d   = {dq_q[DIV_W-2:0], dv_ge};
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_DFIN;
        end
      end

      ST_DFIN: begin
        res_d   = sat_mag(PROD_W'(dq_q) + PROD_W'(dv_rnd), neg_q);
        state_d = ST_UPD;
      end

      ST_UPD: begin
        level_d = sat_sum({level_q[DATA_W-1], level_q} + {res_q[DATA_W-1], res_q});
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (out_load) begin
          out_level_d = level_q;
          out_err_d   = err_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q      <= DATA_W'(65536);
      drain_q     <= '0;
      gain_q      <= DATA_W'(65536);
      coeff_q     <= DATA_W'(65536);
      count_q     <= DATA_W'(65536);
      init_q      <= '0;
      dt_q        <= DT_W'(655);
      state_q     <= ST_IDLE;
      ph_q        <= PH_P1;
      cnt_q       <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      area_q      <= area_d;
      drain_q     <= drain_d;
      gain_q      <= gain_d;
      coeff_q     <= coeff_d;
      count_q     <= count_d;
      init_q      <= init_d;
      dt_q        <= dt_d;
      state_q     <= state_d;
      ph_q        <= ph_d;
      cnt_q       <= cnt_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    u_q         <= u_d;
    err_q       <= err_d;
    rad_q       <= rad_d;
    root_q      <= root_d;
    srem_q      <= srem_d;
    prod_q      <= prod_d;
    mcand_q     <= mcand_d;
    neg_q       <= neg_d;
    res_q       <= res_d;
    p2_q        <= p2_d;
    drem_q      <= drem_d;
    dq_q        <= dq_d;
    out_level_q <= out_level_d;
    out_err_q   <= out_err_d;
  end

endmodule
